@@ hdl/dmm_pkg.sv @@
// shared types and constants for the dense matrix multiply core
// no dependencies
package dmm_pkg;

	localparam int DEF_MAX_DIM = 8;
	localparam int DATA_W = 16;
	localparam int SUM_W = 35;
	localparam int CFG_W = 4;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [1:0] {
		OP_LOAD_A = 2'd0,
		OP_LOAD_B = 2'd1,
		OP_START  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROWS_A    = 2'd0,
		REG_INNER_DIM = 2'd1,
		REG_COLS_B    = 2'd2,
		REG_NONE      = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	// control shared by every cell of the chain
	typedef struct packed {
		logic mul_en;
		logic acc_en;
		logic acc_clr;
		logic shift;
	} cell_ctl_t;

endpackage

@@ hdl/dmm_in_if.sv @@
// input item channel: element loads and start items
// no dependencies
interface dmm_in_if;
	logic valid;
	logic ready;
	logic [1:0] op;
	logic [2:0] row_index;
	logic [2:0] col_index;
	logic signed [15:0] elem_value;

	modport source (output valid, op, row_index, col_index, elem_value, input ready);
	modport sink (input valid, op, row_index, col_index, elem_value, output ready);
endinterface

@@ hdl/dmm_out_if.sv @@
// result channel: one entry of the product matrix per transfer
// no dependencies
interface dmm_out_if;
	logic valid;
	logic ready;
	logic [2:0] out_row;
	logic [2:0] out_col;
	logic signed [34:0] out_value;
	logic is_last;

	modport source (output valid, out_row, out_col, out_value, is_last, input ready);
	modport sink (input valid, out_row, out_col, out_value, is_last, output ready);
endinterface

@@ hdl/dmm_cfg_if.sv @@
// configuration write channel: register index and data
// no dependencies
interface dmm_cfg_if;
	logic valid;
	logic ready;
	logic [1:0] index;
	logic [3:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/dmm_cell.sv @@
// one multiply-accumulate cell of the chain, one result column per cell
// depends on dmm_pkg
module dmm_cell (
	input  logic clk,
	input  logic arst_n,
	input  dmm_pkg::cell_ctl_t ctl,
	input  logic signed [dmm_pkg::DATA_W-1:0] a,
	input  logic signed [dmm_pkg::DATA_W-1:0] b,
	input  logic signed [dmm_pkg::SUM_W-1:0] shift_in,
	output logic signed [dmm_pkg::SUM_W-1:0] acc
);
	import dmm_pkg::*;

	logic signed [2*DATA_W-1:0] prod_s2;
	logic signed [SUM_W-1:0] acc_q;
	logic signed [SUM_W-1:0] base;

	assign base = ctl.acc_clr ? '0 : acc_q;
	assign acc = acc_q;

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_s2 <= a * b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.acc_en) begin
			acc_q <= base + SUM_W'(prod_s2);
		end else if (ctl.shift) begin
			// results move one cell toward the output
			acc_q <= shift_in;
		end
	end
endmodule

@@ hdl/dense_matrix_multiply_core.sv @@
// dense matrix multiply core: operand stores, sequencer and the chain of MAC cells
// depends on dmm_pkg, dmm_in_if, dmm_out_if, dmm_cfg_if, dmm_cell
//
// channel   dir  payload                                   transfer
// items     in   op, row_index, col_index, elem_value      valid & ready
// results   out  out_row, out_col, out_value, is_last      valid & ready
// cfg       in   index, data                               valid & ready
//
// the block is ready for loads whenever it is idle
// a start runs row by row: inner_dim reads of the operand stores, a drain of the
// cell pipeline, then cols_b result transfers, each of which can stall
// the row loop is set by the single left store read port and the cell pipeline
// results stall in place in the cell chain; no item is taken until the last transfer
// reset clears control and sets the dimension registers to (8, 8, 8); stores are not cleared
module dense_matrix_multiply_core #(
	parameter int MAX_DIM = dmm_pkg::DEF_MAX_DIM
) (
	input logic clk,
	input logic arst_n,
	dmm_in_if.sink items,
	dmm_out_if.source results,
	dmm_cfg_if.sink cfg
);
	import dmm_pkg::*;

	localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam logic [4:0] MD5 = 5'(MAX_DIM);

	state_t state_q, state_d;

	logic [CFG_W-1:0] rows_a_q, inner_dim_q, cols_b_q;
	logic [IW-1:0] nr_m1_q, nk_m1_q, nc_m1_q;
	logic [IW-1:0] i_q, j_q, k_q;

	logic signed [DATA_W-1:0] left_mem [MAX_DIM][MAX_DIM];
	logic [MAX_DIM-1:0][DATA_W-1:0] right_mem [MAX_DIM];

	logic signed [DATA_W-1:0] a_s1;
	logic [MAX_DIM-1:0][DATA_W-1:0] brow_s1;
	logic rd_v_s1, first_s1, mul_v_s2, first_s2;

	logic [7:0] row_ext, col_ext, i_ext, j_ext;
	logic load_ok, in_xfer, out_xfer, cfg_xfer, rd_en;
	logic row_done, mat_done;
	cell_ctl_t ctl;
	logic signed [SUM_W-1:0] acc [MAX_DIM];

	function automatic logic [IW-1:0] last_idx(input logic [CFG_W-1:0] v);
		logic [4:0] v5;
		logic [4:0] r5;
		v5 = 5'(v);
		if (v5 == 5'd0) r5 = 5'd0;
		else if (v5 > MD5) r5 = MD5 - 5'd1;
		else r5 = v5 - 5'd1;
		return r5[IW-1:0];
	endfunction

	assign cfg.ready = 1'b1;
	assign cfg_xfer = cfg.valid && cfg.ready;
	assign items.ready = (state_q == ST_IDLE);
	assign in_xfer = items.valid && items.ready;
	assign out_xfer = results.valid && results.ready;

	assign row_ext = 8'(items.row_index);
	assign col_ext = 8'(items.col_index);
	assign load_ok = (int'(items.row_index) < MAX_DIM) && (int'(items.col_index) < MAX_DIM);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q <= 4'd8;
			inner_dim_q <= 4'd8;
			cols_b_q <= 4'd8;
		end else if (cfg_xfer) begin
			unique case (reg_idx_t'(cfg.index))
				REG_ROWS_A: rows_a_q <= cfg.data;
				REG_INNER_DIM: inner_dim_q <= cfg.data;
				REG_COLS_B: cols_b_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// operand stores
	always_ff @(posedge clk) begin
		if (in_xfer && load_ok && op_t'(items.op) == OP_LOAD_A) begin
			left_mem[row_ext[IW-1:0]][col_ext[IW-1:0]] <= items.elem_value;
		end
		if (rd_en) begin
			a_s1 <= left_mem[i_q][k_q];
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && load_ok && op_t'(items.op) == OP_LOAD_B) begin
			right_mem[row_ext[IW-1:0]][col_ext[IW-1:0]] <= items.elem_value;
		end
		if (rd_en) begin
			brow_s1 <= right_mem[k_q];
		end
	end

	assign rd_en = (state_q == ST_MAC);
	assign row_done = (j_q == nc_m1_q);
	assign mat_done = row_done && (i_q == nr_m1_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rd_v_s1 <= 1'b0;
			first_s1 <= 1'b0;
			mul_v_s2 <= 1'b0;
			first_s2 <= 1'b0;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			nr_m1_q <= '0;
			nk_m1_q <= '0;
			nc_m1_q <= '0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= rd_en;
			first_s1 <= rd_en && (k_q == '0);
			mul_v_s2 <= rd_v_s1;
			first_s2 <= first_s1;
			if (in_xfer && op_t'(items.op) == OP_START) begin
				nr_m1_q <= last_idx(rows_a_q);
				nk_m1_q <= last_idx(inner_dim_q);
				nc_m1_q <= last_idx(cols_b_q);
				i_q <= '0;
				j_q <= '0;
				k_q <= '0;
			end
			if (rd_en) begin
				k_q <= (k_q == nk_m1_q) ? '0 : k_q + 1'b1;
			end
			if (out_xfer) begin
				if (row_done) begin
					j_q <= '0;
					i_q <= mat_done ? '0 : i_q + 1'b1;
				end else begin
					j_q <= j_q + 1'b1;
				end
			end
		end
	end

	always_comb begin
		state_d = state_q;
		ctl.mul_en = rd_v_s1;
		ctl.acc_en = mul_v_s2;
		ctl.acc_clr = first_s2;
		ctl.shift = out_xfer;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer && op_t'(items.op) == OP_START) state_d = ST_MAC;
			end
			ST_MAC: begin
				if (k_q == nk_m1_q) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				// sums are final once the product pipeline has emptied
				if (!rd_v_s1 && !mul_v_s2) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_xfer && row_done) state_d = mat_done ? ST_IDLE : ST_MAC;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	for (genvar c = 0; c < MAX_DIM; c++) begin : g_cell
		logic signed [SUM_W-1:0] nxt;
		if (c == MAX_DIM - 1) begin : g_end
			assign nxt = '0;
		end else begin : g_mid
			assign nxt = acc[c+1];
		end
		dmm_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ctl(ctl),
			.a(a_s1),
			.b(brow_s1[c]),
			.shift_in(nxt),
			.acc(acc[c])
		);
	end

	assign i_ext = 8'(i_q);
	assign j_ext = 8'(j_q);
	assign results.valid = (state_q == ST_EMIT);
	assign results.out_row = i_ext[2:0];
	assign results.out_col = j_ext[2:0];
	assign results.out_value = acc[0];
	assign results.is_last = mat_done;

	// no item input while results of a multiply are pending
	a_in_excl: assert property (@(posedge clk) disable iff (!arst_n)
		items.ready |-> !results.valid) else $error("input ready during emit");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_xfer && results.is_last) |=> items.ready) else $error("no return to idle");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> (j_q <= nc_m1_q) && (i_q <= nr_m1_q)) else $error("index range");

	a_no_mix: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.acc_en && ctl.shift)) else $error("accumulate during shift");

endmodule
